>>> hdl/ncnw_pkg.sv
// shared types, constants and step tables for the node-counting waypoint block
package ncnw_pkg;

   localparam int CSR_ADDR_BITS = 2;
   localparam logic [CSR_ADDR_BITS-1:0] REG_NEAR_RADIUS_SQ = '0;
   localparam logic [15:0] RADIUS_RESET = 16'd2621;

   localparam logic KIND_MAP  = 1'b0;
   localparam logic KIND_POSE = 1'b1;

   localparam int NUM_DIRS = 8;
   localparam logic [3:0] NO_DIR = 4'd8;

   typedef logic signed [15:0] q88_type;
   typedef logic signed [8:0]  node_type;
   typedef logic [2:0]         dir_type;

   // unit steps, clockwise from north
   function automatic logic signed [1:0] step_dx(input dir_type d);
      logic signed [1:0] s;
      unique case (d)
         3'd0: s = 2'sd0;
         3'd1: s = 2'sd1;
         3'd2: s = 2'sd1;
         3'd3: s = 2'sd1;
         3'd4: s = 2'sd0;
         3'd5: s = -2'sd1;
         3'd6: s = -2'sd1;
         default: s = -2'sd1;
      endcase
      return s;
   endfunction

   function automatic logic signed [1:0] step_dy(input dir_type d);
      logic signed [1:0] s;
      unique case (d)
         3'd0: s = 2'sd1;
         3'd1: s = 2'sd1;
         3'd2: s = 2'sd0;
         3'd3: s = -2'sd1;
         3'd4: s = -2'sd1;
         3'd5: s = -2'sd1;
         3'd6: s = 2'sd0;
         default: s = 2'sd1;
      endcase
      return s;
   endfunction

endpackage

>>> hdl/ncnw_if.sv
// request and response channel interfaces
interface ncnw_req_if import ncnw_pkg::*; ();
   logic        valid;
   logic        ready;
   logic        kind;
   q88_type     pose_x;
   q88_type     pose_y;
   logic [3:0]  cell_x;
   logic [3:0]  cell_y;
   logic [15:0] cell_count;

   modport source(output valid, kind, pose_x, pose_y, cell_x, cell_y, cell_count,
                  input ready);
   modport sink(input valid, kind, pose_x, pose_y, cell_x, cell_y, cell_count,
                output ready);
endinterface

interface ncnw_rsp_if import ncnw_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       in_node;
   logic       new_node;
   node_type   nearest_x;
   node_type   nearest_y;
   logic       decided;
   logic       found;
   logic [3:0] direction;
   node_type   target_x;
   node_type   target_y;

   modport source(output valid, in_node, new_node, nearest_x, nearest_y, decided, found,
                  direction, target_x, target_y, input ready);
   modport sink(input valid, in_node, new_node, nearest_x, nearest_y, decided, found,
                direction, target_x, target_y, output ready);
endinterface

>>> hdl/node_counting_next_waypoint.sv
// node-counting explorer: visit-count map memory, pose rounding and neighbour scan
//
// req carries words of two kinds. an in-grid map word (kind 0) stores one visit
// count into the grid memory in the cycle it is accepted and gives no response. a
// pose word (kind 1) gives exactly one rsp word: the rounded node, whether the
// robot sits inside the arrival radius, the sticky new-node flag and, while
// that flag is set, the neighbour picked as the next target.
// a pose word without a scan raises rsp valid after the states round, square,
// decide and output. with a scan it passes the scan state before output, where
// the eight neighbour counts come one per cycle through the single read port of
// the map memory and each is compared once its registered read has returned.
// one pose word is in work at a time; req is ready again in the cycle the
// response appears. after reset the block clears all (2*HALF_SIZE+1)^2 entries
// of the map memory (121 by default), one per cycle; req ready stays low
// meanwhile, while apb writes are taken as usual. the radius register resets
// to 2621.
// the response sits in an output register: a stalled rsp does not stop the
// block from accepting the next word, but the following response waits until
// the held one has been taken.
module node_counting_next_waypoint import ncnw_pkg::*; #(
   parameter int HALF_SIZE  = 5,
   parameter int COUNT_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   ncnw_req_if.sink                 req,
   ncnw_rsp_if.source               rsp,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);

   localparam int GRID_SIDE  = 2 * HALF_SIZE + 1;
   localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
   localparam int ADDR_BITS  = $clog2(GRID_CELLS);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_ROUND, S_SQUARE, S_DECIDE, S_SCAN, S_OUT
   } state_type;

   logic [15:0] near_radius_sq;

   ncnw_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .near_radius_sq(near_radius_sq)
   );

   function automatic node_type round_q88(input q88_type v);
      logic signed [16:0] v_wide;
      logic [16:0]        mag;
      logic [16:0]        sum;
      logic [8:0]         n;
      v_wide = 17'(v);
      mag    = (v_wide < 0) ? 17'(-v_wide) : 17'(v_wide);
      sum    = mag + 17'd128;
      n      = sum[16:8];
      return v[15] ? node_type'(-n) : node_type'(n);
   endfunction

   // control and payload registers
   state_type             state_ff;
   logic [ADDR_BITS-1:0]  clr_addr_ff;
   q88_type               px_ff, py_ff;
   node_type              nx_ff, ny_ff;
   logic signed [8:0]     dx_ff, dy_ff;
   logic [14:0]           sqx_ff, sqy_ff;
   logic                  inside_ff;
   node_type              last_x_ff, last_y_ff;
   logic                  last_known_ff;
   logic                  flag_ff;
   logic [3:0]            issue_ff;
   logic                  pend_valid_ff;
   dir_type               pend_dir_ff;
   logic                  found_ff;
   logic                  zero_hit_ff;
   logic [COUNT_BITS-1:0] best_ff;
   dir_type               dir_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_in_node_ff, rsp_new_node_ff, rsp_decided_ff, rsp_found_ff;
   node_type              rsp_nearest_x_ff, rsp_nearest_y_ff;
   node_type              rsp_target_x_ff, rsp_target_y_ff;
   logic [3:0]            rsp_direction_ff;

   // map memory
   logic [COUNT_BITS-1:0] count_mem [GRID_CELLS];
   logic [COUNT_BITS-1:0] rd_data_ff;
   logic                  mem_we;
   logic [ADDR_BITS-1:0]  mem_waddr;
   logic [COUNT_BITS-1:0] mem_wdata;
   logic [ADDR_BITS-1:0]  map_addr;
   logic                  map_inb;
   logic                  req_fire;

   // neighbour address of the direction being issued
   dir_type               scan_dir;
   logic signed [9:0]     nb_ix, nb_iy;
   logic                  nb_inb;
   logic [ADDR_BITS-1:0]  nb_addr;

   // pose arithmetic
   node_type              nx_in, ny_in;
   logic signed [16:0]    offx, offy;
   logic signed [17:0]    prodx, prody;
   logic [15:0]           dsq;
   logic                  in_radius;
   logic                  flag_in;
   logic                  rsp_free;
   node_type              tgt_x, tgt_y;

   assign req_fire = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE);
   assign rsp_free = !rsp_valid_ff || rsp.ready;

   assign map_inb  = (req.cell_x < GRID_SIDE) && (req.cell_y < GRID_SIDE);
   assign map_addr = ADDR_BITS'(req.cell_x * GRID_SIDE + req.cell_y);

   always_comb begin
      scan_dir = issue_ff[2:0];
      nb_ix    = 10'(nx_ff) + 10'(HALF_SIZE) + 10'(step_dx(scan_dir));
      nb_iy    = 10'(ny_ff) + 10'(HALF_SIZE) + 10'(step_dy(scan_dir));
      nb_inb   = (nb_ix >= 0) && (nb_ix < GRID_SIDE) && (nb_iy >= 0) && (nb_iy < GRID_SIDE);
      nb_addr  = ADDR_BITS'(nb_ix * GRID_SIDE + nb_iy);
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = map_addr;
      mem_wdata = COUNT_BITS'(req.cell_count);
      if (state_ff == S_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
      end else if (req_fire && req.kind == KIND_MAP && map_inb) begin
         mem_we = 1'b1;
      end
   end

   // writes only happen in idle or clear, read data is only used in scan: no overlap
   always_ff @(posedge clock) begin
      if (mem_we) begin
         count_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= count_mem[nb_addr];
   end

   always_comb begin
      nx_in     = round_q88(px_ff);
      ny_in     = round_q88(py_ff);
      offx      = 17'(px_ff) - 17'({nx_in, 8'b0});
      offy      = 17'(py_ff) - 17'({ny_in, 8'b0});
      prodx     = 18'(dx_ff) * 18'(dx_ff);
      prody     = 18'(dy_ff) * 18'(dy_ff);
      dsq       = {1'b0, sqx_ff} + {1'b0, sqy_ff};
      in_radius = dsq <= near_radius_sq;
      flag_in   = in_radius ? (!last_known_ff || last_x_ff != nx_ff || last_y_ff != ny_ff)
                            : flag_ff;
      tgt_x     = found_ff ? node_type'(nx_ff + 9'(step_dx(dir_ff))) : nx_ff;
      tgt_y     = found_ff ? node_type'(ny_ff + 9'(step_dy(dir_ff))) : ny_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_addr_ff   <= '0;
         last_known_ff <= 1'b0;
         last_x_ff     <= '0;
         last_y_ff     <= '0;
         flag_ff       <= 1'b0;
         issue_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // in the output state the load below decides rsp valid
         if (rsp_valid_ff && rsp.ready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
               if (clr_addr_ff == ADDR_BITS'(GRID_CELLS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               px_ff <= req.pose_x;
               py_ff <= req.pose_y;
               if (req_fire && req.kind == KIND_POSE) begin
                  state_ff <= S_ROUND;
               end
            end
            S_ROUND: begin
               nx_ff    <= nx_in;
               ny_ff    <= ny_in;
               dx_ff    <= offx[8:0];
               dy_ff    <= offy[8:0];
               state_ff <= S_SQUARE;
            end
            S_SQUARE: begin
               sqx_ff   <= prodx[14:0];
               sqy_ff   <= prody[14:0];
               state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               inside_ff     <= in_radius;
               flag_ff       <= flag_in;
               if (in_radius) begin
                  last_x_ff     <= nx_ff;
                  last_y_ff     <= ny_ff;
                  last_known_ff <= 1'b1;
               end
               issue_ff      <= '0;
               pend_valid_ff <= 1'b0;
               found_ff      <= 1'b0;
               zero_hit_ff   <= 1'b0;
               best_ff       <= '0;
               dir_ff        <= '0;
               state_ff      <= flag_in ? S_SCAN : S_OUT;
            end
            S_SCAN: begin
               // read issued for one direction, compared in the cycle after
               if (issue_ff != 4'(NUM_DIRS)) begin
                  issue_ff      <= issue_ff + 1'b1;
                  pend_valid_ff <= nb_inb;
                  pend_dir_ff   <= scan_dir;
               end else begin
                  pend_valid_ff <= 1'b0;
                  state_ff      <= S_OUT;
               end
               if (pend_valid_ff && !zero_hit_ff) begin
                  if (rd_data_ff == '0) begin
                     found_ff    <= 1'b1;
                     zero_hit_ff <= 1'b1;
                     dir_ff      <= pend_dir_ff;
                  end else if (!found_ff || rd_data_ff < best_ff) begin
                     found_ff <= 1'b1;
                     best_ff  <= rd_data_ff;
                     dir_ff   <= pend_dir_ff;
                  end
               end
            end
            S_OUT: begin
               if (rsp_free) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_in_node_ff   <= inside_ff;
                  rsp_new_node_ff  <= flag_ff;
                  rsp_nearest_x_ff <= nx_ff;
                  rsp_nearest_y_ff <= ny_ff;
                  rsp_decided_ff   <= flag_ff;
                  rsp_found_ff     <= flag_ff && found_ff;
                  rsp_direction_ff <= (flag_ff && found_ff) ? {1'b0, dir_ff} : NO_DIR;
                  rsp_target_x_ff  <= flag_ff ? tgt_x : nx_ff;
                  rsp_target_y_ff  <= flag_ff ? tgt_y : ny_ff;
                  state_ff         <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.in_node   = rsp_in_node_ff;
   assign rsp.new_node  = rsp_new_node_ff;
   assign rsp.nearest_x = rsp_nearest_x_ff;
   assign rsp.nearest_y = rsp_nearest_y_ff;
   assign rsp.decided   = rsp_decided_ff;
   assign rsp.found     = rsp_found_ff;
   assign rsp.direction = rsp_direction_ff;
   assign rsp.target_x  = rsp_target_x_ff;
   assign rsp.target_y  = rsp_target_y_ff;

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req.ready)
      else $error("word accepted during map clear");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("response raised outside output state");

   a_scan_needs_flag: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> flag_ff)
      else $error("neighbour scan without new-node flag");

   a_found_has_dir: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_found_ff) |-> (rsp_decided_ff && rsp_direction_ff != NO_DIR))
      else $error("found response without direction");

endmodule

>>> hdl/ncnw_csr.sv
// apb register file holding the squared arrival radius
module ncnw_csr import ncnw_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready,
   output logic [15:0]              near_radius_sq
);

   logic [15:0]              radius_ff;
   logic [CSR_ADDR_BITS-1:0] reg_index;
   logic                     wr_en;

   assign reg_index = paddr >> 2;
   assign wr_en     = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (wr_en && reg_index == REG_NEAR_RADIUS_SQ) begin
         radius_ff <= pwdata[15:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_index == REG_NEAR_RADIUS_SQ) begin
         prdata = {16'b0, radius_ff};
      end
   end

   assign near_radius_sq = radius_ff;

endmodule
